// File: src/semp_pkg.sv
// Package for the stack engine: command and status codes, widths, defaults.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package semp_pkg;
  localparam int unsigned DefaultDepth = 32;
  localparam int unsigned CmdW = 3;
  localparam int unsigned StW = 3;
  localparam int unsigned DataW = 32;
  localparam int unsigned CharW = 7;

  localparam logic [CmdW-1:0] CMD_PUSH  = 3'd0;
  localparam logic [CmdW-1:0] CMD_MOD   = 3'd1;
  localparam logic [CmdW-1:0] CMD_PCHAR = 3'd2;
  localparam logic [CmdW-1:0] CMD_PSTR  = 3'd3;
  localparam logic [CmdW-1:0] CMD_ROTL  = 3'd4;

  localparam logic [StW-1:0] ST_OK      = 3'd0;
  localparam logic [StW-1:0] ST_SHORT   = 3'd1;
  localparam logic [StW-1:0] ST_DIVZERO = 3'd2;
  localparam logic [StW-1:0] ST_RANGE   = 3'd3;
  localparam logic [StW-1:0] ST_EMPTY   = 3'd4;
  localparam logic [StW-1:0] ST_FULL    = 3'd5;

  localparam logic [CharW-1:0] NEWLINE_CHAR = 7'd10;
  localparam logic [CharW-1:0] CHAR_MAX_VAL = 7'd127;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD1   = 9'b000000010,
    S_RD2   = 9'b000000100,
    S_DIV   = 9'b000001000,
    S_WB    = 9'b000010000,
    S_PCHR  = 9'b000100000,
    S_PSTR  = 9'b001000000,
    S_EMIT  = 9'b010000000,
    S_ROTL  = 9'b100000000
  } state_e;
endpackage
`default_nettype wire

// File: src/stack_engine_mod_print_rotate_unit.sv
// Stack engine top level: ring-buffer stack in one synchronous RAM, serial divider.
// Depends on semp_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Push and early errors answer straight from idle; rotl reads the top and writes it below
// the base; pchar char word after the top read, newline the cycle after it is taken.
// mod: two RAM reads (divide by zero reported after them), then a 32-step restoring divider.
// pstr: one RAM read per emitted char, through the single read port.
// One command at a time; the next is taken once the last result word is sent.
// Reset clears count, ring base and control; the stack RAM is not cleared.
module stack_engine_mod_print_rotate_unit
  import semp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DefaultDepth
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [CmdW-1:0]       command_i,
  input  wire logic signed [DataW-1:0] push_value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [CharW-1:0]           char_out_o,
  output logic                       char_valid_o,
  output logic [StW-1:0]             status_code_o,
  output logic                       last_o
);
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  // stack memory, one read and one write per cycle
  logic [DataW-1:0] mem_q [STACK_DEPTH];
  logic [DataW-1:0] rdata_q;
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [DataW-1:0] wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] base_q, base_d;
  logic [CW-1:0] idx_q, idx_d;        // pstr walk position (count of elements left)
  logic [DataW-1:0] top_q, top_d;     // divisor magnitude holder / saved top
  logic [DataW-1:0] quo_q, quo_d;     // dividend shift register
  logic [DataW-1:0] rem_q, rem_d;
  logic [5:0]       step_q, step_d;
  logic             neg_q, neg_d;
  logic [CharW-1:0] ch_q, ch_d;
  logic             cv_q, cv_d, last_q, last_d, oval_q, oval_d;
  logic [StW-1:0]   st_q, st_d;
  logic             pend_q, pend_d;   // newline pending after the pchar char

  // slot of position pos: (base + pos) mod depth; pos < depth, one compare-subtract
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] b, input logic [CW-1:0] p);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, b} + {1'b0, p};
    if (s >= (CW+1)'(STACK_DEPTH)) s = s - (CW+1)'(STACK_DEPTH);
    return s[AW-1:0];
  endfunction

  assign in_ready_o    = (state_q == S_IDLE) && !oval_q;
  assign out_valid_o   = oval_q;
  assign char_out_o    = ch_q;
  assign char_valid_o  = cv_q;
  assign status_code_o = st_q;
  assign last_o        = last_q;

  logic signed [DataW-1:0] rs;
  logic [DataW:0] trial;
  logic in_char;
  assign rs = $signed(rdata_q);
  assign trial = {rem_q, quo_q[DataW-1]} - {1'b0, top_q};
  assign in_char = (rdata_q[DataW-1:CharW] == '0) && (rdata_q[CharW-1:0] != '0);

  always_comb begin
    state_d = state_q; count_d = count_q; base_d = base_q; idx_d = idx_q;
    top_d = top_q; quo_d = quo_q; rem_d = rem_q; step_d = step_q;
    neg_d = neg_q; ch_d = ch_q; cv_d = cv_q; last_d = last_q;
    st_d = st_q; oval_d = oval_q; pend_d = pend_q;
    we = 1'b0; waddr = '0; wdata = '0;
    raddr = slot(base_q, count_q - CW'(1));
    if (oval_q && out_ready_i) oval_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          ch_d = '0; cv_d = 1'b0; st_d = ST_OK; last_d = 1'b1;
          case (command_i)
            CMD_PUSH: begin
              if (count_q >= CW'(STACK_DEPTH)) begin
                st_d = ST_FULL;
              end else begin
                we = 1'b1; waddr = slot(base_q, count_q);
                wdata = push_value_i; count_d = count_q + CW'(1);
              end
              oval_d = 1'b1;
            end
            CMD_MOD: begin
              if (count_q < CW'(2)) begin
                st_d = ST_SHORT; oval_d = 1'b1;
              end else begin
                state_d = S_RD1;        // top read issued now
              end
            end
            CMD_PCHAR: begin
              if (count_q == '0) begin
                st_d = ST_EMPTY; oval_d = 1'b1;
              end else begin
                state_d = S_PCHR;
              end
            end
            CMD_PSTR: begin
              idx_d = count_q;
              state_d = S_PSTR;
            end
            CMD_ROTL: begin
              if (count_q >= CW'(2)) state_d = S_ROTL;
              else oval_d = 1'b1;
            end
            default: oval_d = 1'b1;
          endcase
        end
      end
      S_RD1: begin
        // top arrived; read second
        top_d = rdata_q;
        raddr = slot(base_q, count_q - CW'(2));
        state_d = S_RD2;
      end
      S_RD2: begin
        if (top_q == '0) begin
          st_d = ST_DIVZERO; oval_d = 1'b1; state_d = S_IDLE;
        end else begin
          neg_d = rdata_q[DataW-1];
          quo_d = rdata_q[DataW-1] ? (~rdata_q + 1'b1) : rdata_q;
          top_d = top_q[DataW-1] ? (~top_q + 1'b1) : top_q;
          rem_d = '0; step_d = '0; state_d = S_DIV;
        end
      end
      S_DIV: begin
        // restoring step, one quotient bit per cycle; remainder only kept
        if (!trial[DataW]) rem_d = trial[DataW-1:0];
        else rem_d = {rem_q[DataW-2:0], quo_q[DataW-1]};
        quo_d = {quo_q[DataW-2:0], 1'b0};
        step_d = step_q + 6'd1;
        if (step_q == 6'(DataW - 1)) state_d = S_WB;
      end
      S_WB: begin
        we = 1'b1; waddr = slot(base_q, count_q - CW'(2));
        wdata = neg_q ? (~rem_q + 1'b1) : rem_q;
        count_d = count_q - CW'(1);
        oval_d = 1'b1; state_d = S_IDLE;
      end
      S_PCHR: begin
        if (rs < 0 || rs > $signed({{(DataW-CharW){1'b0}}, CHAR_MAX_VAL})) begin
          st_d = ST_RANGE; oval_d = 1'b1; state_d = S_IDLE;
        end else begin
          ch_d = rdata_q[CharW-1:0]; cv_d = 1'b1; last_d = 1'b0;
          oval_d = 1'b1; pend_d = 1'b1; state_d = S_EMIT;
        end
      end
      S_PSTR: begin
        // rdata holds position idx-1 (issued previous cycle) when idx > 0
        if (idx_q == '0 || !in_char) begin
          ch_d = NEWLINE_CHAR; cv_d = 1'b1; last_d = 1'b1;
          oval_d = 1'b1; state_d = S_IDLE;
        end else begin
          ch_d = rdata_q[CharW-1:0]; cv_d = 1'b1; last_d = 1'b0;
          oval_d = 1'b1; idx_d = idx_q - CW'(1); state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the char word is taken, then continue
        raddr = slot(base_q, idx_q - CW'(1));
        if (!oval_q || out_ready_i) begin
          if (pend_q) begin
            pend_d = 1'b0; ch_d = NEWLINE_CHAR; cv_d = 1'b1; last_d = 1'b1;
            oval_d = 1'b1; state_d = S_IDLE;
          end else begin
            state_d = S_PSTR;
          end
        end
      end
      S_ROTL: begin
        base_d = (base_q == '0) ? AW'(STACK_DEPTH - 1) : base_q - AW'(1);
        we = 1'b1; waddr = base_d; wdata = rdata_q;
        oval_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // pstr entry issues first read at top
    if (state_q == S_IDLE) raddr = slot(base_q, count_q - CW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= '0; base_q <= '0; oval_q <= 1'b0;
      pend_q <= 1'b0; idx_q <= '0; step_q <= '0;
    end else begin
      state_q <= state_d; count_q <= count_d; base_q <= base_d; oval_q <= oval_d;
      pend_q <= pend_d; idx_q <= idx_d; step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d; quo_q <= quo_d; rem_q <= rem_d; neg_q <= neg_d;
    ch_q <= ch_d; cv_q <= cv_d; last_q <= last_d; st_q <= st_d;
  end
endmodule
`default_nettype wire
